@@ rtl/adt_pkg.sv @@
// Shared constants, codes and types of the alarm deadline table.
`timescale 1ns / 1ps

package adt_pkg;

   localparam int DEFAULT_MAX_ALARMS = 16;

   localparam int TIME_W   = 32;
   localparam int TAG_W    = 8;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 56;

   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TIME = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANG     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NONE_DUE = 3'd4;

   typedef struct packed {
      logic              overdue;
      logic              better;
      logic [TIME_W-1:0] delay;
   } cmp_result_type;

endpackage

@@ rtl/alarm_deadline_table.sv @@
// A result goes into the output register after its word is accepted and the table scanned, once that register is free.
// The scan covers n entries: the count before a delete, tick or refused set, or after a set.
// The scan makes one memory read per cycle.
// A new word is taken only in idle, after the result of the last one has gone to the output register.
// The output register lets the next word in while a result waits; a second result stalls.
// Reset is synchronous and empties the table at once; the slot memory is not cleared.
`timescale 1ns / 1ps

module alarm_deadline_table #(
   parameter int MAX_ALARMS = adt_pkg::DEFAULT_MAX_ALARMS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // current_time, alarm_tag, absolute_time, delay_seconds
   input  logic [adt_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [adt_pkg::KIND_W-1:0]     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // rang_tag, next_valid, next_tag, next_delay, alarm_count, zero padding
   output logic [adt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [adt_pkg::STATUS_W-1:0]   rsp_tuser
);

   localparam int AW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
   localparam int CW = $clog2(MAX_ALARMS + 1);
   localparam int TW = adt_pkg::TIME_W;
   localparam int GW = adt_pkg::TAG_W;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;
   typedef enum logic [1:0] {DROP_NONE, DROP_TAG, DROP_TIME} drop_type;

   state_type                      state_ff, state_in;
   drop_type                       mode_ff, mode_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [CW-1:0]                  scan_len_ff, scan_len_in;
   logic [CW-1:0]                  src_ff, src_in;
   logic [CW-1:0]                  dst_ff, dst_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic [TW-1:0]                  now_ff, now_in;
   logic [GW-1:0]                  tag_ff, tag_in;
   logic [adt_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic                           found_ff, found_in;
   logic [GW-1:0]                  rang_ff, rang_in;
   logic                           best_valid_ff, best_valid_in;
   logic [TW-1:0]                  best_delay_ff, best_delay_in;
   logic [GW-1:0]                  best_tag_ff, best_tag_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [adt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [adt_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic [TW-1:0] mem_time [MAX_ALARMS];
   logic [GW-1:0] mem_tag  [MAX_ALARMS];
   logic [TW-1:0] rd_time_ff;
   logic [GW-1:0] rd_tag_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [TW-1:0] wr_time;
   logic [GW-1:0] wr_tag;
   logic          issue;
   logic          drop;

   logic [TW-1:0] in_now;
   logic [GW-1:0] in_tag;
   logic [TW-1:0] in_abs;
   logic [TW-1:0] in_delay;
   logic [TW:0]   sum;
   logic [TW-1:0] sat_time;

   adt_pkg::cmp_result_type cmp;

   assign in_now   = req_tdata[31:0];
   assign in_tag   = req_tdata[39:32];
   assign in_abs   = req_tdata[71:40];
   assign in_delay = req_tdata[103:72];
   assign sum      = {1'b0, in_now} + {1'b0, in_delay};
   assign sat_time = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   adt_cmp_unit u_cmp (
      .slot_time  (rd_time_ff),
      .now_time   (now_ff),
      .best_valid (best_valid_ff),
      .best_delay (best_delay_ff),
      .result     (cmp)
   );

   assign issue = (state_ff == ST_SCAN) && (src_ff < scan_len_ff);
   assign drop  = ((mode_ff == DROP_TAG) && (rd_tag_ff == tag_ff)) ||
                  ((mode_ff == DROP_TIME) && cmp.overdue);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      scan_len_in   = scan_len_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      rd_vld_in     = 1'b0;
      now_in        = now_ff;
      tag_in        = tag_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rang_in       = rang_ff;
      best_valid_in = best_valid_ff;
      best_delay_in = best_delay_ff;
      best_tag_in   = best_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_time       = (in_abs != '0) ? in_abs : sat_time;
      wr_tag        = in_tag;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in      = ST_SCAN;
               mode_in       = DROP_NONE;
               now_in        = in_now;
               tag_in        = in_tag;
               src_in        = '0;
               dst_in        = '0;
               found_in      = 1'b0;
               rang_in       = '0;
               best_valid_in = 1'b0;
               best_delay_in = '0;
               best_tag_in   = '0;
               scan_len_in   = count_ff;
               status_in     = adt_pkg::STATUS_DONE;
               case (req_tuser)
                  adt_pkg::KIND_SET: begin
                     if (count_ff >= CW'(MAX_ALARMS)) begin
                        status_in = adt_pkg::STATUS_FULL;
                     end else if ((in_abs == '0) && (in_delay[TW-1] || (in_delay == '0))) begin
                        status_in = adt_pkg::STATUS_BAD_TIME;
                     end else begin
                        wr_en       = 1'b1;
                        scan_len_in = count_ff + CW'(1);
                     end
                  end
                  adt_pkg::KIND_DELETE: begin
                     mode_in = DROP_TAG;
                  end
                  adt_pkg::KIND_TICK: begin
                     mode_in   = DROP_TIME;
                     status_in = adt_pkg::STATUS_NONE_DUE;
                  end
                  default: begin
                     mode_in = DROP_NONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_vld_in = issue;
            if (issue) begin
               src_in = src_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (drop) begin
                  if (!found_ff && (mode_ff == DROP_TIME)) begin
                     found_in = 1'b1;
                     rang_in  = rd_tag_ff;
                  end
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = dst_ff[AW-1:0];
                  wr_time = rd_time_ff;
                  wr_tag  = rd_tag_ff;
                  dst_in  = dst_ff + CW'(1);
                  if (!cmp.overdue && cmp.better) begin
                     best_valid_in = 1'b1;
                     best_delay_in = cmp.delay;
                     best_tag_in   = rd_tag_ff;
                  end
               end
            end
            if (!issue && !rd_vld_ff) begin
               count_in = dst_ff;
               state_in = ST_FINISH;
               if ((mode_ff == DROP_TIME) && found_ff) begin
                  status_in = adt_pkg::STATUS_RANG;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = {2'b00, adt_pkg::COUNT_W'(count_ff), best_delay_ff,
                                best_tag_ff, best_valid_ff, rang_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         scan_len_ff   <= scan_len_in;
         src_ff        <= src_in;
         dst_ff        <= dst_in;
         rd_vld_ff     <= rd_vld_in;
         now_ff        <= now_in;
         tag_ff        <= tag_in;
         status_ff     <= status_in;
         found_ff      <= found_in;
         rang_ff       <= rang_in;
         best_valid_ff <= best_valid_in;
         best_delay_ff <= best_delay_in;
         best_tag_ff   <= best_tag_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_time[wr_addr] <= wr_time;
         mem_tag[wr_addr]  <= wr_tag;
      end
      rd_time_ff <= mem_time[src_ff[AW-1:0]];
      rd_tag_ff  <= mem_tag[src_ff[AW-1:0]];
   end

endmodule

@@ rtl/adt_cmp_unit.sv @@
// Shared time compare and subtract unit used once per scanned slot.
`timescale 1ns / 1ps

module adt_cmp_unit (
   input  logic [adt_pkg::TIME_W-1:0] slot_time,
   input  logic [adt_pkg::TIME_W-1:0] now_time,
   input  logic                       best_valid,
   input  logic [adt_pkg::TIME_W-1:0] best_delay,
   output adt_pkg::cmp_result_type    result
);

   logic [adt_pkg::TIME_W-1:0] delay;

   assign delay          = slot_time - now_time;
   assign result.overdue = (slot_time <= now_time);
   assign result.delay   = delay;
   assign result.better  = !best_valid || (delay < best_delay);

endmodule

@@ rtl/adt_checker.sv @@
// Port-level checker for the alarm deadline table, bound to the top level.
`timescale 1ns / 1ps

module adt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [adt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [adt_pkg::STATUS_W-1:0]   rsp_tuser
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result word valid after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result word changed.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= adt_pkg::STATUS_NONE_DUE))
      else $error("Result status out of range.");

   a_rang_tag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != adt_pkg::STATUS_RANG) |-> (rsp_tdata[7:0] == '0))
      else $error("Rang tag set without an alarm ringing.");

   a_next_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] |-> (rsp_tdata[16:9] == '0) && (rsp_tdata[48:17] == '0))
      else $error("Next alarm fields set without a future alarm.");

endmodule

bind alarm_deadline_table adt_checker u_adt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
